[hw/rtl/matinv_pkg.sv]
// Shared types, widths and the saturation helper for the 3x3 matrix inverse unit.
// No dependencies; used by every module of the block.
package matinv_pkg;

   localparam int ElemW       = 32;   // Q16.16 element
   localparam int AdjW        = 64;   // cofactor, wraps like a 64-bit signed value
   localparam int DetW        = 98;   // exact determinant, Q50.48
   localparam int QuoW        = 32;   // quotient bits, one per divider step
   localparam int ThrW        = 31;
   localparam int NumElem     = 9;
   localparam int FrontStages = 7;
   localparam int PipeStages  = FrontStages + QuoW;

   typedef struct packed {
      logic signed [ElemW-1:0] m00;
      logic signed [ElemW-1:0] m01;
      logic signed [ElemW-1:0] m02;
      logic signed [ElemW-1:0] m10;
      logic signed [ElemW-1:0] m11;
      logic signed [ElemW-1:0] m12;
      logic signed [ElemW-1:0] m20;
      logic signed [ElemW-1:0] m21;
      logic signed [ElemW-1:0] m22;
   } req_data_type;

   typedef struct packed {
      logic signed [ElemW-1:0] inv00;
      logic signed [ElemW-1:0] inv01;
      logic signed [ElemW-1:0] inv02;
      logic signed [ElemW-1:0] inv10;
      logic signed [ElemW-1:0] inv11;
      logic signed [ElemW-1:0] inv12;
      logic signed [ElemW-1:0] inv20;
      logic signed [ElemW-1:0] inv21;
      logic signed [ElemW-1:0] inv22;
      logic signed [ElemW-1:0] det_value;
      logic                    singular;
   } rsp_data_type;

   // State of one matrix inside the divider pipeline.
   typedef struct packed {
      logic [DetW-1:0]                 dmag;
      logic [NumElem-1:0][DetW-1:0]    rem;
      logic [NumElem-1:0][QuoW-1:0]    quo;
      logic [NumElem-1:0]              neg;
      logic [NumElem-1:0]              ovf;
      logic                            sing;
      logic [ElemW-1:0]                det_value;
   } div_pipe_type;

   // Sign and magnitude to saturated two's complement; ovf means magnitude >= 2^32.
   function automatic logic [ElemW-1:0] sat_q(input logic neg, input logic ovf,
                                              input logic [QuoW-1:0] q);
      logic [ElemW-1:0] lim;
      logic [ElemW-1:0] m;
      lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      m   = (ovf || (q > lim)) ? lim : q;
      return neg ? (~m + 32'd1) : m;
   endfunction

endpackage

[hw/rtl/matinv_front.sv]
// Front pipeline: cofactor products, adjugate, determinant, magnitude and singular test.
// Depends on matinv_pkg; feeds the first matinv_div_step.
module matinv_front import matinv_pkg::*; (
   input  logic                clock,
   input  logic                en,
   input  req_data_type        req_data,
   input  logic [ThrW-1:0]     thr,
   output div_pipe_type        init_ff
);

   logic signed [ElemW-1:0] m [3][3];

   assign m[0][0] = req_data.m00;
   assign m[0][1] = req_data.m01;
   assign m[0][2] = req_data.m02;
   assign m[1][0] = req_data.m10;
   assign m[1][1] = req_data.m11;
   assign m[1][2] = req_data.m12;
   assign m[2][0] = req_data.m20;
   assign m[2][1] = req_data.m21;
   assign m[2][2] = req_data.m22;

   logic signed [AdjW-1:0]   pa_ff   [NumElem];
   logic signed [AdjW-1:0]   pb_ff   [NumElem];
   logic signed [AdjW-1:0]   adj_ff  [NumElem];
   logic [AdjW-1:0]          cm_f2   [NumElem];
   logic [AdjW-1:0]          cm_f3   [NumElem];
   logic [AdjW-1:0]          cm_f4   [NumElem];
   logic [AdjW-1:0]          cm_f5   [NumElem];
   logic [NumElem-1:0]       as_f2, as_f3, as_f4, as_f5;
   logic signed [ElemW-1:0]  m0_f0   [3];
   logic signed [ElemW-1:0]  m0_f1   [3];
   logic signed [63:0]       ph_ff   [3];
   logic signed [64:0]       pl_ff   [3];
   logic signed [95:0]       prod_ff [3];
   logic signed [DetW-1:0]   det_ff;
   logic [DetW-1:0]          dmag_ff;
   logic                     dneg_ff;

   for (genvar r = 0; r < 3; r++) begin : g_row
      for (genvar c = 0; c < 3; c++) begin : g_col
         localparam int R0 = (c + 1) % 3;
         localparam int R1 = (c + 2) % 3;
         localparam int C0 = (r + 1) % 3;
         localparam int C1 = (r + 2) % 3;
         localparam int K  = r * 3 + c;

         always_ff @(posedge clock) begin
            if (en) begin
               pa_ff[K]  <= 64'(m[R0][C0]) * 64'(m[R1][C1]);
               pb_ff[K]  <= 64'(m[R0][C1]) * 64'(m[R1][C0]);
               adj_ff[K] <= pa_ff[K] - pb_ff[K];
               cm_f2[K]  <= adj_ff[K][AdjW-1] ? AdjW'(-adj_ff[K]) : AdjW'(adj_ff[K]);
               as_f2[K]  <= adj_ff[K][AdjW-1];
               cm_f3[K]  <= cm_f2[K];
               cm_f4[K]  <= cm_f3[K];
               cm_f5[K]  <= cm_f4[K];
               as_f3[K]  <= as_f2[K];
               as_f4[K]  <= as_f3[K];
               as_f5[K]  <= as_f4[K];
               init_ff.rem[K] <= DetW'(cm_f5[K]);
               init_ff.quo[K] <= '0;
               init_ff.neg[K] <= dneg_ff ^ as_f5[K];
               // quotient reaches 2^32 exactly when |adj| >= |det|
               init_ff.ovf[K] <= DetW'(cm_f5[K]) >= dmag_ff;
            end
         end
      end
   end

   // det = sum over c of m[0][c] * adj[c][0]; 32x64 split into two 32x32 halves
   for (genvar c = 0; c < 3; c++) begin : g_det
      always_ff @(posedge clock) begin
         if (en) begin
            m0_f0[c]   <= m[0][c];
            m0_f1[c]   <= m0_f0[c];
            ph_ff[c]   <= 64'(m0_f1[c]) * 64'($signed(adj_ff[c*3][AdjW-1:32]));
            pl_ff[c]   <= 65'(m0_f1[c]) * $signed({33'b0, adj_ff[c*3][31:0]});
            prod_ff[c] <= $signed({ph_ff[c], 32'b0}) + 96'(pl_ff[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         det_ff  <= DetW'(prod_ff[0]) + DetW'(prod_ff[1]) + DetW'(prod_ff[2]);
         dneg_ff <= det_ff[DetW-1];
         dmag_ff <= det_ff[DetW-1] ? DetW'(-det_ff) : DetW'(det_ff);
         init_ff.dmag      <= dmag_ff;
         init_ff.sing      <= DetW'({thr, 32'b0}) >= dmag_ff;
         init_ff.det_value <= sat_q(dneg_ff, |dmag_ff[DetW-1:64], dmag_ff[63:32]);
      end
   end

endmodule

[hw/rtl/matinv_div_step.sv]
// One restoring-division step for all nine quotients: one quotient bit per lane.
// Depends on matinv_pkg; chained QuoW times in the top level.
module matinv_div_step import matinv_pkg::*; (
   input  logic          clock,
   input  logic          en,
   input  div_pipe_type  d_in,
   output div_pipe_type  d_ff
);

   div_pipe_type d_in_next;
   logic [DetW:0] sh   [NumElem];
   logic [DetW:0] diff [NumElem];

   always_comb begin
      d_in_next = d_in;
      for (int k = 0; k < NumElem; k++) begin
         sh[k]   = {d_in.rem[k], 1'b0};
         diff[k] = sh[k] - {1'b0, d_in.dmag};
         if (sh[k] >= {1'b0, d_in.dmag}) begin
            d_in_next.rem[k] = diff[k][DetW-1:0];
            d_in_next.quo[k] = {d_in.quo[k][QuoW-2:0], 1'b1};
         end else begin
            d_in_next.rem[k] = sh[k][DetW-1:0];
            d_in_next.quo[k] = {d_in.quo[k][QuoW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= d_in_next;
      end
   end

endmodule

[hw/rtl/matrix_inverse_3x3_unit.sv]
// Top level of the 3x3 matrix inverse unit: valid tracking, divider chain, output skid.
// Depends on matinv_pkg, matinv_front and matinv_div_step.
//
// Usage:
//   req_valid/req_stall/req_data carry one matrix per beat (nine Q16.16 elements).
//   rsp_valid/rsp_stall/rsp_data return the inverse, the saturated determinant and
//   the singular flag, one result beat per matrix, in order.
//   csr_write_enable/csr_write_data set the singular threshold (unsigned Q15.16, 31 bits);
//   write only while no matrix is in flight.
// Timing:
//   A matrix enters every cycle while req_stall is low. Its result passes through
//   7 stages of products, cofactors and determinant, 32 divider stages (one
//   quotient bit each, nine lanes side by side) and the output register.
// Reset clears all valid bits and the threshold to zero.
// When rsp_stall holds a result, the next arriving result parks in a skid
// register; only then does the pipeline freeze and req_stall rise. req_stall
// comes straight from a flop.
module matrix_inverse_3x3_unit import matinv_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_data_type    req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_data_type    rsp_data,
   input  logic            csr_write_enable,
   input  logic [ThrW-1:0] csr_write_data
);

   logic [ThrW-1:0]       thr_ff;
   logic [PipeStages-1:0] v_ff;
   logic                  rsp_v_ff;
   logic                  sk_v_ff;
   rsp_data_type          rsp_data_ff;
   rsp_data_type          sk_data_ff;
   rsp_data_type          arr_data;
   logic                  en;
   logic                  take;
   logic                  arrive;
   div_pipe_type          chain [QuoW+1];
   logic [ElemW-1:0]      inv [NumElem];

   assign en        = !sk_v_ff;
   assign req_stall = sk_v_ff;
   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_data_ff;
   assign take      = rsp_v_ff && !rsp_stall;
   assign arrive    = en && v_ff[PipeStages-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else if (csr_write_enable) begin
         thr_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[PipeStages-2:0], req_valid};
      end
   end

   matinv_front u_front (
      .clock    (clock),
      .en       (en),
      .req_data (req_data),
      .thr      (thr_ff),
      .init_ff  (chain[0])
   );

   for (genvar i = 0; i < QuoW; i++) begin : g_div
      matinv_div_step u_step (
         .clock (clock),
         .en    (en),
         .d_in  (chain[i]),
         .d_ff  (chain[i+1])
      );
   end

   always_comb begin
      for (int k = 0; k < NumElem; k++) begin
         inv[k] = chain[QuoW].sing ? '0 :
                  sat_q(chain[QuoW].neg[k], chain[QuoW].ovf[k], chain[QuoW].quo[k]);
      end
      arr_data.inv00     = inv[0];
      arr_data.inv01     = inv[1];
      arr_data.inv02     = inv[2];
      arr_data.inv10     = inv[3];
      arr_data.inv11     = inv[4];
      arr_data.inv12     = inv[5];
      arr_data.inv20     = inv[6];
      arr_data.inv21     = inv[7];
      arr_data.inv22     = inv[8];
      arr_data.det_value = chain[QuoW].det_value;
      arr_data.singular  = chain[QuoW].sing;
   end

   // output register plus one skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
         sk_v_ff  <= 1'b0;
      end else if (!rsp_v_ff || take) begin
         if (sk_v_ff) begin
            rsp_v_ff <= 1'b1;
            sk_v_ff  <= 1'b0;
         end else begin
            rsp_v_ff <= arrive;
         end
      end else if (arrive) begin
         sk_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_v_ff || take) begin
         rsp_data_ff <= sk_v_ff ? sk_data_ff : arr_data;
      end else if (arrive) begin
         sk_data_ff <= arr_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      sk_v_ff |-> rsp_v_ff)
      else $error("skid holds a beat while the output register is empty");

   assert property (@(posedge clock) disable iff (reset)
      $rose(sk_v_ff) |-> $past(rsp_v_ff && rsp_stall))
      else $error("skid filled without a stalled output beat");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_v_ff && rsp_data_ff.singular) |->
         (rsp_data_ff.inv00 == 0 && rsp_data_ff.inv01 == 0 && rsp_data_ff.inv02 == 0 &&
          rsp_data_ff.inv10 == 0 && rsp_data_ff.inv11 == 0 && rsp_data_ff.inv12 == 0 &&
          rsp_data_ff.inv20 == 0 && rsp_data_ff.inv21 == 0 && rsp_data_ff.inv22 == 0))
      else $error("singular beat carries a nonzero inverse element");

   assert property (@(posedge clock) disable iff (reset)
      (sk_v_ff && !take) |=> (sk_v_ff && $stable(v_ff)))
      else $error("pipeline moved while the skid was full");

endmodule
